>>> rtl/brb_pkg.sv
// shared types and constants for the byte ring buffer with pattern find
package brb_pkg;

  localparam int unsigned Depth      = 1024;
  localparam int unsigned AddrW      = $clog2(Depth);
  localparam int unsigned FillW      = AddrW + 1;
  localparam int unsigned MaxBurst   = 64;
  localparam int unsigned MaxPattern = 8;
  localparam int unsigned PatCntW    = $clog2(MaxPattern + 1);

  localparam logic [7:0]  BlankChar  = 8'h5E;
  localparam logic [15:0] OvfMax     = 16'hFFFF;

  // operation codes
  typedef enum logic [2:0] {
    OP_PUSH  = 3'd0,
    OP_POP   = 3'd1,
    OP_DROP  = 3'd2,
    OP_PEEK  = 3'd3,
    OP_BLANK = 3'd4,
    OP_FIND  = 3'd5,
    OP_FLUSH = 3'd6,
    OP_NONE  = 3'd7
  } op_e;

  // configuration register indexes
  localparam logic [0:0] REG_PATTERN = 1'd0;
  localparam logic [0:0] REG_PATLEN  = 1'd1;

  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  data_byte;
    logic [6:0]  amount;
    logic [9:0]  offset;
    logic [10:0] window;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  data_out;
    logic        valid_res;
    logic        last;
    logic        found;
    logic [9:0]  match_position;
    logic [10:0] searched_span;
    logic [10:0] fill_level;
    logic [15:0] overflow_total;
  } out_beat_t;

  // memory port request from the sequencer
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

endpackage

>>> rtl/brb_if.sv
// valid/ready channel carrying one payload beat
interface brb_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/byte_ring_buffer_with_pattern_find.sv
// Byte ring buffer with pattern find. Push, drop tail and flush register
// their result beat at the accept; the next item is taken once that beat
// has left. Pop and peek go per byte through store read issue, read data
// capture and result beat; blank writes its bytes one after another, then
// gives the result beat; find issues a store read, then compares, for each
// pattern byte, as the 1024-byte store has a single read port. Find restarts compare at each
// candidate start. Results leave through a registered output and a stalled
// receiver holds the input; no clearing pass is needed after reset.
module byte_ring_buffer_with_pattern_find (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  brb_if.sink         in_if,
  brb_if.source       out_if
);
  brb_pkg::mem_req_t mem;
  logic [7:0] rdata;

  brb_seq u_seq (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i (in_if.valid), .in_ready_o (in_if.ready), .in_beat_i (in_if.payload),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready), .out_beat_o(out_if.payload),
    .mem_o(mem), .rdata_i(rdata)
  );

  brb_ram #(.Words(brb_pkg::Depth)) u_ram (
    .clk_i, .we_i(mem.we), .waddr_i(mem.waddr), .wdata_i(mem.wdata),
    .re_i(mem.re), .raddr_i(mem.raddr), .rdata_o(rdata)
  );
endmodule

>>> rtl/brb_ram.sv
// byte store: one write port, one registered read port
module brb_ram #(
  parameter int unsigned Words = 1024,
  parameter int unsigned AW    = $clog2(Words)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);
  logic [7:0] mem [Words];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule

>>> rtl/brb_seq.sv
// sequencer: pointers, counters, burst and search control around the byte store
module brb_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [63:0]                  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  brb_pkg::in_beat_t            in_beat_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output brb_pkg::out_beat_t           out_beat_o,
  output brb_pkg::mem_req_t            mem_o,
  input  logic [7:0]                   rdata_i
);
  localparam int unsigned AW = brb_pkg::AddrW;
  localparam int unsigned FW = brb_pkg::FillW;

  typedef enum logic [2:0] {
    S_IDLE, S_POP, S_PEEK, S_BLANK, S_FIND, S_OUT
  } state_e;

  state_e state_q;
  logic [AW-1:0] rp_q, wp_q;
  logic [FW-1:0] fill_q;
  logic [15:0]   ovf_q;
  logic [63:0]   pat_q;
  logic [3:0]    plen_q;

  // burst / search working registers
  logic [6:0]    left_q;      // bytes still to issue
  logic [AW-1:0] ptr_q;       // next address to issue
  logic [FW-1:0] avail_q;
  logic [FW-1:0] span_q;
  logic [FW-1:0] cand_q;      // candidate start relative to offset
  logic [2:0]    dig_q;       // byte within pattern
  logic          rd_pend_q;
  logic [9:0]    off_q;

  brb_pkg::out_beat_t ob_q;
  logic out_v_q;

  logic [3:0] plen_eff;
  always_comb begin
    plen_eff = plen_q;
    if (plen_q == 4'd0) plen_eff = 4'd1;
    if (plen_q > 4'(brb_pkg::MaxPattern)) plen_eff = 4'(brb_pkg::MaxPattern);
  end

  logic [6:0] amt_sat;
  assign amt_sat = (in_beat_i.amount > 7'(brb_pkg::MaxBurst)) ?
                   7'(brb_pkg::MaxBurst) : in_beat_i.amount;

  logic [FW-1:0] avail_in;
  assign avail_in = ({1'b0, in_beat_i.offset} < fill_q) ?
                    fill_q - FW'(in_beat_i.offset) : '0;

  logic [FW-1:0] n_pop, n_rng;
  assign n_pop = (FW'(amt_sat) < fill_q) ? FW'(amt_sat) : fill_q;
  assign n_rng = (FW'(amt_sat) < avail_in) ? FW'(amt_sat) : avail_in;

  logic [7:0] pat_byte;
  assign pat_byte = pat_q[{dig_q, 3'b000} +: 8];

  assign in_ready_o  = (state_q == S_IDLE) && !out_v_q;
  assign out_valid_o = out_v_q;
  assign out_beat_o  = ob_q;

  logic in_fire, out_fire;
  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_v_q && out_ready_i;

  // memory requests
  always_comb begin
    mem_o = '0;
    mem_o.waddr = ptr_q;
    mem_o.raddr = ptr_q;
    mem_o.wdata = brb_pkg::BlankChar;
    if (in_fire && in_beat_i.operation == brb_pkg::OP_PUSH &&
        fill_q < FW'(brb_pkg::Depth)) begin
      mem_o.we    = 1'b1;
      mem_o.waddr = wp_q;
      mem_o.wdata = in_beat_i.data_byte;
    end
    if (state_q == S_BLANK && left_q != '0) mem_o.we = 1'b1;
    if ((state_q == S_POP || state_q == S_PEEK) && left_q != '0 && !rd_pend_q)
      mem_o.re = 1'b1;
    if (state_q == S_FIND && !rd_pend_q) begin
      mem_o.re    = 1'b1;
      mem_o.raddr = ptr_q + AW'(cand_q) + AW'(dig_q);
    end
  end

  function automatic brb_pkg::out_beat_t mk(logic v, logic [FW-1:0] f, logic [15:0] o);
    brb_pkg::out_beat_t b;
    b = '0;
    b.valid_res = v;
    b.last = 1'b1;
    b.fill_level = f;
    b.overflow_total = o;
    return b;
  endfunction

  // add the byte read and the last flag to a result beat
  function automatic brb_pkg::out_beat_t mk_data(brb_pkg::out_beat_t b, logic [7:0] d,
                                                 logic l);
    brb_pkg::out_beat_t r;
    r = b;
    r.data_out = d;
    r.last = l;
    return r;
  endfunction

  // add the search outcome to a result beat
  function automatic brb_pkg::out_beat_t mk_find(brb_pkg::out_beat_t b, logic [FW-1:0] s,
                                                 logic h, logic [9:0] p);
    brb_pkg::out_beat_t r;
    r = b;
    r.searched_span = s;
    r.found = h;
    r.match_position = p;
    return r;
  endfunction

  // control state and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rp_q <= '0; wp_q <= '0; fill_q <= '0; ovf_q <= '0;
      pat_q <= '0; plen_q <= 4'd1;
      out_v_q <= 1'b0; rd_pend_q <= 1'b0;
      left_q <= '0; ptr_q <= '0; avail_q <= '0; span_q <= '0;
      cand_q <= '0; dig_q <= '0; off_q <= '0; ob_q <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == brb_pkg::REG_PATTERN) pat_q <= cfg_data_i;
        else plen_q <= cfg_data_i[3:0];
      end
      if (out_fire) out_v_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            off_q <= in_beat_i.offset;
            case (in_beat_i.operation)
              brb_pkg::OP_PUSH: begin
                out_v_q <= 1'b1;
                if (fill_q < FW'(brb_pkg::Depth)) begin
                  wp_q <= wp_q + 1'b1;
                  fill_q <= fill_q + 1'b1;
                  ob_q <= mk(1'b1, fill_q + 1'b1, ovf_q);
                end else begin
                  if (ovf_q != brb_pkg::OvfMax) ovf_q <= ovf_q + 1'b1;
                  ob_q <= mk(1'b0, fill_q,
                             (ovf_q != brb_pkg::OvfMax) ? ovf_q + 1'b1 : ovf_q);
                end
              end
              brb_pkg::OP_POP: begin
                if (n_pop == '0) begin
                  out_v_q <= 1'b1; ob_q <= mk(1'b0, fill_q, ovf_q);
                end else begin
                  left_q <= n_pop[6:0]; ptr_q <= rp_q; state_q <= S_POP;
                end
              end
              brb_pkg::OP_DROP: begin
                wp_q <= wp_q - AW'(n_pop);
                fill_q <= fill_q - n_pop;
                out_v_q <= 1'b1;
                ob_q <= mk(n_pop != '0, fill_q - n_pop, ovf_q);
              end
              brb_pkg::OP_PEEK, brb_pkg::OP_BLANK: begin
                if (n_rng == '0) begin
                  out_v_q <= 1'b1; ob_q <= mk(1'b0, fill_q, ovf_q);
                end else begin
                  left_q <= n_rng[6:0];
                  ptr_q <= rp_q + AW'(in_beat_i.offset);
                  state_q <= (in_beat_i.operation == brb_pkg::OP_PEEK) ?
                             S_PEEK : S_BLANK;
                end
              end
              brb_pkg::OP_FIND: begin
                if (avail_in == '0) begin
                  out_v_q <= 1'b1; ob_q <= mk(1'b0, fill_q, ovf_q);
                end else begin
                  avail_q <= avail_in;
                  span_q  <= (in_beat_i.window < avail_in) ? in_beat_i.window : avail_in;
                  ptr_q   <= rp_q + AW'(in_beat_i.offset);
                  cand_q  <= '0; dig_q <= '0;
                  state_q <= S_FIND;
                end
              end
              brb_pkg::OP_FLUSH: begin
                out_v_q <= 1'b1;
                if (fill_q != '0) begin
                  rp_q <= '0; wp_q <= '0; fill_q <= '0; ovf_q <= '0;
                  ob_q <= mk(1'b1, '0, '0);
                end else begin
                  ob_q <= mk(1'b0, fill_q, ovf_q);
                end
              end
              default: begin
                out_v_q <= 1'b1; ob_q <= mk(1'b0, fill_q, ovf_q);
              end
            endcase
          end
        end
        S_POP, S_PEEK: begin
          // issue one read, then present its byte
          if (!rd_pend_q && !out_v_q) begin
            rd_pend_q <= 1'b1;
            ptr_q <= ptr_q + 1'b1;
            left_q <= left_q - 1'b1;
            if (state_q == S_POP) begin
              rp_q <= rp_q + 1'b1;
              fill_q <= fill_q - 1'b1;
            end
          end else if (rd_pend_q) begin
            rd_pend_q <= 1'b0;
            out_v_q <= 1'b1;
            ob_q <= mk_data(mk(1'b1, fill_q, ovf_q), rdata_i, left_q == '0);
            if (left_q == '0) state_q <= S_IDLE;
          end
        end
        S_BLANK: begin
          ptr_q <= ptr_q + 1'b1;
          left_q <= left_q - 1'b1;
          if (left_q == 7'd1) begin
            state_q <= S_IDLE;
            out_v_q <= 1'b1; ob_q <= mk(1'b1, fill_q, ovf_q);
          end
        end
        S_FIND: begin
          // candidate loop: stop when out of room or past the span
          if (!rd_pend_q) begin
            if (cand_q + FW'(plen_eff) > avail_q || cand_q > span_q) begin
              state_q <= S_IDLE; out_v_q <= 1'b1;
              ob_q <= mk_find(mk(1'b1, fill_q, ovf_q), span_q, 1'b0, '0);
            end else begin
              rd_pend_q <= 1'b1;
            end
          end else begin
            rd_pend_q <= 1'b0;
            if (rdata_i != pat_byte) begin
              cand_q <= cand_q + 1'b1; dig_q <= '0;
            end else if (4'(dig_q) + 4'd1 == plen_eff) begin
              state_q <= S_IDLE; out_v_q <= 1'b1;
              ob_q <= mk_find(mk(1'b1, fill_q, ovf_q), span_q, 1'b1,
                              off_q + 10'(cand_q));
            end else begin
              dig_q <= dig_q + 1'b1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(brb_pkg::Depth)) else $error("fill above depth");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ready_o) else $error("accept while busy");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (AW'(wp_q - rp_q) == AW'(fill_q)))
    else $error("pointers disagree with fill");
`endif
endmodule
